// ===== sv/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the state slot allocator: pool size, index
// and count widths, result status codes, and the free queue control words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 64;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;

    // Request operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_HOLDS   = 3'd2,
        ST_UNUSED  = 3'd3,
        ST_NOTHING = 3'd4
    } status_t;

    // Commands into the free queue
    typedef struct packed {
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] push_slot;
    } fq_cmd_t;

    // Status out of the free queue
    typedef struct packed {
        logic [SLOT_W-1:0] head_slot;
        logic [CNT_W-1:0]  count;
    } fq_stat_t;

    // Advance a circular queue index, wrapping at the end of the pool
    function automatic logic [SLOT_W-1:0] next_idx(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W-1:0] res;
        if (idx == SLOT_W'(POOL_SIZE - 1))
            res = '0;
        else
            res = idx + SLOT_W'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssa_free_queue.sv =====
// ----------------------------------------------------------------------------
// ssa_free_queue
// Circular free list of slot numbers held in a synchronous memory. Entries
// that were never written read back as their own index, tracked by the tail
// position and a wrap mark instead of a clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssa_free_queue
    import ssa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fq_cmd_t  cmd,
    output fq_stat_t      stat
);

    logic [SLOT_W-1:0] mem [POOL_SIZE];

    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] head_next;
    logic [SLOT_W-1:0] tail_reg;
    logic [SLOT_W-1:0] tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              wrapped_reg;
    logic              wrapped_next;

    logic [SLOT_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic              rd_written_reg;
    logic              head_written;

    // An index holds written data once the tail has passed it
    assign head_written = wrapped_reg || (head_reg < tail_reg);

    // Advance head, tail and count on pop and push
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        wrapped_next = wrapped_reg;
        if (cmd.pop)
        begin
            head_next  = next_idx(head_reg);
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.push)
        begin
            tail_next = next_idx(tail_reg);
            if (tail_reg == SLOT_W'(POOL_SIZE - 1))
                wrapped_next = 1'b1;
            if (count_reg < CNT_W'(POOL_SIZE))
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= CNT_W'(POOL_SIZE);
            wrapped_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // Write released slots at the tail
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[tail_reg] <= cmd.push_slot;
    end

    // Read the head entry every cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg    <= mem[head_reg];
        rd_idx_reg     <= head_reg;
        rd_written_reg <= head_written;
    end

    assign stat.head_slot = rd_written_reg ? rd_data_reg : rd_idx_reg;
    assign stat.count     = count_reg;

endmodule

`default_nettype wire

// ===== sv/state_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// state_slot_allocator
// FIFO free-list allocator over a fixed pool of state slots.
// ----------------------------------------------------------------------------
// Each request is accepted and then decided: on the accept edge the queue
// head and the in-use bit of the named slot are read from their memories,
// and on the commit edge the request is decided, both memories are written
// back and the result word is loaded into the output register. The block
// returns to idle after each commit and takes a new request only there, so
// it cannot take a request before the previous one commits; a stalled
// result holds the pending request in its decide state. No clearing pass
// follows reset: the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module state_slot_allocator
    import ssa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic              operation,
    input  wire logic [SLOT_W-1:0] slot_number,
    input  wire logic              holds_slot,

    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic [SLOT_W-1:0]      granted_slot,
    output logic [2:0]             status,
    output logic                   more_available
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t            state_reg;
    state_t            state_next;

    logic              op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              holds_reg;

    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [SLOT_W-1:0] granted_reg;
    status_t           status_reg;
    logic              more_reg;

    logic              accept;
    logic              commit;

    fq_cmd_t           fq_cmd;
    fq_stat_t          fq_stat;

    // In-use map: memory plus one valid bit per entry
    logic              iu_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] iu_valid_reg;
    logic [SLOT_W-1:0] iu_rd_addr;
    logic              iu_rd_data_reg;
    logic              iu_rd_valid_reg;
    logic              in_use;
    logic              iu_we;
    logic [SLOT_W-1:0] iu_wr_addr;
    logic              iu_wr_data;

    // Decision results
    status_t           dec_status;
    logic [SLOT_W-1:0] dec_granted;
    logic              dec_more;

    assign accept    = (state_reg == S_IDLE) && req_valid;
    assign commit    = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = (state_reg != S_IDLE);

    // Hold the request while it is decided
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            slot_reg  <= slot_number;
            holds_reg <= holds_slot;
        end
    end

    // Sequence accept and decide
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Read the in-use bit at the incoming slot, then keep re-reading it
    assign iu_rd_addr = (state_reg == S_IDLE) ? slot_number : slot_reg;
    assign in_use     = iu_rd_valid_reg && iu_rd_data_reg;

    always_ff @(posedge clk)
    begin
        iu_rd_data_reg <= iu_mem[iu_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iu_rd_valid_reg <= 1'b0;
        else
            iu_rd_valid_reg <= iu_valid_reg[iu_rd_addr];
    end

    // Decide the request
    always_comb
    begin
        dec_status    = ST_OK;
        dec_granted   = '0;
        fq_cmd.pop    = 1'b0;
        fq_cmd.push   = 1'b0;
        fq_cmd.push_slot = slot_reg;
        iu_we         = 1'b0;
        iu_wr_addr    = slot_reg;
        iu_wr_data    = 1'b0;
        dec_more      = (fq_stat.count != '0);
        if (op_reg == OP_ALLOC)
        begin
            if (holds_reg)
                dec_status = ST_HOLDS;
            else if (fq_stat.count == '0)
                dec_status = ST_EMPTY;
            else
            begin
                dec_granted = fq_stat.head_slot;
                fq_cmd.pop  = commit;
                iu_we       = commit;
                iu_wr_addr  = fq_stat.head_slot;
                iu_wr_data  = 1'b1;
                dec_more    = (fq_stat.count != CNT_W'(1));
            end
        end
        else
        begin
            if (!holds_reg)
                dec_status = ST_NOTHING;
            else if (!in_use)
                dec_status = ST_UNUSED;
            else
            begin
                fq_cmd.push = commit;
                iu_we       = commit;
                iu_wr_data  = 1'b0;
                dec_more    = 1'b1;
            end
        end
    end

    // Write back the in-use map
    always_ff @(posedge clk)
    begin
        if (iu_we)
            iu_mem[iu_wr_addr] <= iu_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iu_valid_reg <= '0;
        else if (iu_we)
            iu_valid_reg[iu_wr_addr] <= 1'b1;
    end

    ssa_free_queue u_free_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fq_cmd),
        .stat  (fq_stat)
    );

    // Load the result word; drop it once taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (commit)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            granted_reg <= dec_granted;
            status_reg  <= dec_status;
            more_reg    <= dec_more;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign granted_slot   = granted_reg;
    assign status         = status_reg;
    assign more_available = more_reg;

endmodule

`default_nettype wire
